>>> rtl/lfba_pkg.sv
// Shared types, command and status codes, and helpers for the block allocator.
package lfba_pkg;

	localparam int unsigned UNIQ_W = 32;
	localparam int unsigned WORD_W = 64;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_MARK    = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_CHECK   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_WRONG   = 2'd2;

	// Status of the unique counter as seen by the command sequencer.
	typedef struct packed {
		logic              busy;
		logic [UNIQ_W-1:0] next_value;
		logic              persist_next;
	} uniq_status_t;

	// Position of the lowest set bit; an all-zero word gives 63.
	function automatic logic [5:0] lowest_set(input logic [WORD_W-1:0] v);
		logic [5:0] n;
		n = 6'd63;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				n = 6'(i);
			end
		end
		return n;
	endfunction

endpackage

>>> rtl/lowest_first_block_allocator.sv
// Lowest-first block slot allocator: bitmap with two summary levels in memories.
// Allocate: the result follows a chain of dependent reads through the upper summary, summary
//   and bitmap memories; no new command is accepted until the result is given.
// Mark used, release and check: one read of each memory, then modify; no overlap of commands.
// No space or a slot beyond the slot count: answered at the accept edge, one per cycle while busy is low.
// Reset starts a clearing pass over all 2^(SLOT_BITS-6) bitmap words (1024 by default);
//   a start value write starts its reduction. busy covers both; results are never held.
module lowest_first_block_allocator #(
	parameter int unsigned SLOT_BITS        = 16,
	parameter int unsigned PERSIST_INTERVAL = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [15:0] block_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] slot_out,
	output logic [31:0] uniq_value,
	output logic        persist_uniq
);

	// Sizes of the three levels. The bitmap holds one bit per slot, the summary one bit
	// per bitmap word, the upper summary one bit per summary word, and the top vector
	// one bit per upper summary word. Index widths never drop below one bit.
	localparam int unsigned NUM_WORDS = 1 << (SLOT_BITS - 6);
	localparam int unsigned NUM_SUM   = (SLOT_BITS > 12) ? (1 << (SLOT_BITS - 12)) : 1;
	localparam int unsigned NUM_MID   = (SLOT_BITS > 18) ? (1 << (SLOT_BITS - 18)) : 1;
	localparam int unsigned WB = (SLOT_BITS > 6)  ? SLOT_BITS - 6  : 1;
	localparam int unsigned SB = (SLOT_BITS > 12) ? SLOT_BITS - 12 : 1;
	localparam int unsigned MB = (SLOT_BITS > 18) ? SLOT_BITS - 18 : 1;
	localparam int unsigned WW = lfba_pkg::WORD_W;

	// Reset contents of the summary levels: only existing lower words are marked.
	localparam logic [WW-1:0] SUM_INIT =
		(NUM_WORDS >= WW) ? {WW{1'b1}} : ((WW'(1) << NUM_WORDS) - WW'(1));
	localparam logic [WW-1:0] MID_INIT =
		(NUM_SUM >= WW) ? {WW{1'b1}} : ((WW'(1) << NUM_SUM) - WW'(1));

	// Sequencer states.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_A_MID = 2'd1;
	localparam logic [1:0] S_A_SUM = 2'd2;
	localparam logic [1:0] S_RMW   = 2'd3;

	logic [1:0] state_q, state_d;
	logic [1:0] cmd_q;
	logic [15:0] idx_q;
	logic [MB-1:0] t_q;
	logic [SB-1:0] s_q;
	logic [WB-1:0] w_q;

	// Clearing pass after reset.
	logic          clr_q;
	logic [WB-1:0] clr_idx_q;

	// Top vector in flip-flops, one bit per upper summary word.
	logic [NUM_MID-1:0] top_q;

	// The three memories with their registered read data.
	logic [WW-1:0] free_mem [NUM_WORDS];
	logic [WW-1:0] sum_mem  [NUM_SUM];
	logic [WW-1:0] mid_mem  [NUM_MID];
	logic [WW-1:0] free_rd_q, sum_rd_q, mid_rd_q;

	logic          free_re, free_we;
	logic [WB-1:0] free_raddr, free_waddr;
	logic [WW-1:0] free_wdata;
	logic          sum_re, sum_we;
	logic [SB-1:0] sum_raddr, sum_waddr;
	logic [WW-1:0] sum_wdata;
	logic          mid_re, mid_we;
	logic [MB-1:0] mid_raddr, mid_waddr;
	logic [WW-1:0] mid_wdata;

	lfba_pkg::uniq_status_t uniq;
	logic accept;
	logic cfg_write;
	logic uniq_step;

	// Decode of an accepted beat.
	logic [SLOT_BITS-1:0] named_slot;
	logic                 in_range;
	logic [MB-1:0]        t_pick;
	logic [SB-1:0]        s_pick;
	logic [WB-1:0]        w_pick;

	// Read-modify-write of the chosen word.
	logic [5:0]    pos;
	logic [WW-1:0] bit_mask, sum_mask, mid_mask;
	logic [WW-1:0] new_word, new_sum, new_mid;
	logic          cur_free, do_write, set_free;
	logic [1:0]    rmw_status;
	logic [SLOT_BITS-1:0] grant_slot;

	// Result beat formed this cycle and registered at the edge.
	logic        res_fire;
	logic [1:0]  res_status;
	logic [15:0] res_slot;
	logic [31:0] res_uniq;
	logic        res_persist;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign busy      = clr_q || uniq.busy || (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign uniq_step = (state_q == S_RMW) && (cmd_q == lfba_pkg::CMD_ALLOC);

	lfba_uniq_counter #(
		.PERSIST_INTERVAL(PERSIST_INTERVAL)
	) u_uniq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (cfg_write),
		.load_value (cfg_data),
		.step       (uniq_step),
		.status     (uniq)
	);

	// A named slot is in range when no bit above the slot width is set.
	assign named_slot = SLOT_BITS'(block_index);
	assign in_range   = (SLOT_BITS >= 16) || ((32'(block_index) >> SLOT_BITS) == 32'd0);

	// Allocation walks down the levels: top vector, upper summary, summary, bitmap.
	assign t_pick = MB'(lfba_pkg::lowest_set(WW'(top_q)));
	assign s_pick = SB'({t_q, lfba_pkg::lowest_set(mid_rd_q)});
	assign w_pick = WB'({s_q, lfba_pkg::lowest_set(sum_rd_q)});

	// Modify step: one bit of the bitmap word changes, and the emptiness of each level
	// is carried up to the next one.
	always_comb begin
		pos = (cmd_q == lfba_pkg::CMD_ALLOC) ? lfba_pkg::lowest_set(free_rd_q) : idx_q[5:0];
		cur_free = free_rd_q[pos];
		bit_mask = WW'(1) << pos;
		do_write = 1'b0;
		set_free = 1'b0;
		rmw_status = lfba_pkg::ST_OK;
		unique case (cmd_q)
			lfba_pkg::CMD_ALLOC: begin
				do_write = 1'b1;
			end
			lfba_pkg::CMD_MARK: begin
				do_write   = cur_free;
				rmw_status = cur_free ? lfba_pkg::ST_OK : lfba_pkg::ST_WRONG;
			end
			lfba_pkg::CMD_RELEASE: begin
				do_write   = !cur_free;
				set_free   = 1'b1;
				rmw_status = cur_free ? lfba_pkg::ST_WRONG : lfba_pkg::ST_OK;
			end
			lfba_pkg::CMD_CHECK: begin
				rmw_status = cur_free ? lfba_pkg::ST_WRONG : lfba_pkg::ST_OK;
			end
			default: begin
				do_write = 1'b0;
			end
		endcase
		new_word = set_free ? (free_rd_q | bit_mask) : (free_rd_q & ~bit_mask);
		sum_mask = WW'(1) << 6'(w_q);
		new_sum  = (new_word != '0) ? (sum_rd_q | sum_mask) : (sum_rd_q & ~sum_mask);
		mid_mask = WW'(1) << 6'(s_q);
		new_mid  = (new_sum != '0) ? (mid_rd_q | mid_mask) : (mid_rd_q & ~mid_mask);
		grant_slot = SLOT_BITS'({w_q, pos});
	end

	// Memory ports. The clearing pass owns the write ports while it runs; no command
	// is accepted then, so the two never compete.
	always_comb begin
		free_re    = 1'b0;
		free_raddr = WB'(named_slot >> 6);
		sum_re     = 1'b0;
		sum_raddr  = SB'(named_slot >> 12);
		mid_re     = 1'b0;
		mid_raddr  = MB'(named_slot >> 18);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command == lfba_pkg::CMD_ALLOC) begin
						mid_re    = (top_q != '0);
						mid_raddr = t_pick;
					end else begin
						free_re = in_range;
						sum_re  = in_range;
						mid_re  = in_range;
					end
				end
			end
			S_A_MID: begin
				sum_re    = 1'b1;
				sum_raddr = s_pick;
			end
			S_A_SUM: begin
				free_re    = 1'b1;
				free_raddr = w_pick;
			end
			S_RMW: begin
				free_re = 1'b0;
			end
			default: begin
				free_re = 1'b0;
			end
		endcase

		priority if (clr_q) begin
			free_we    = 1'b1;
			free_waddr = clr_idx_q;
			free_wdata = {WW{1'b1}};
			sum_we     = (32'(clr_idx_q) < NUM_SUM);
			sum_waddr  = SB'(clr_idx_q);
			sum_wdata  = SUM_INIT;
			mid_we     = (32'(clr_idx_q) < NUM_MID);
			mid_waddr  = MB'(clr_idx_q);
			mid_wdata  = MID_INIT;
		end else begin
			free_we    = (state_q == S_RMW) && do_write;
			free_waddr = w_q;
			free_wdata = new_word;
			sum_we     = (state_q == S_RMW) && do_write;
			sum_waddr  = s_q;
			sum_wdata  = new_sum;
			mid_we     = (state_q == S_RMW) && do_write;
			mid_waddr  = t_q;
			mid_wdata  = new_mid;
		end
	end

	always_ff @(posedge clk) begin
		if (free_we) begin
			free_mem[free_waddr] <= free_wdata;
		end
		if (free_re) begin
			free_rd_q <= free_mem[free_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_waddr] <= sum_wdata;
		end
		if (sum_re) begin
			sum_rd_q <= sum_mem[sum_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (mid_we) begin
			mid_mem[mid_waddr] <= mid_wdata;
		end
		if (mid_re) begin
			mid_rd_q <= mid_mem[mid_raddr];
		end
	end

	// Sequencer and result forming. A beat that needs no memory is answered at once.
	always_comb begin
		state_d     = state_q;
		res_fire    = 1'b0;
		res_status  = lfba_pkg::ST_OK;
		res_slot    = idx_q;
		res_uniq    = '0;
		res_persist = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (command == lfba_pkg::CMD_ALLOC) begin
						if (top_q != '0) begin
							state_d = S_A_MID;
						end else begin
							res_fire   = 1'b1;
							res_status = lfba_pkg::ST_NOSPACE;
							res_slot   = '0;
						end
					end else if (in_range) begin
						state_d = S_RMW;
					end else begin
						res_fire   = 1'b1;
						res_status = lfba_pkg::ST_WRONG;
						res_slot   = block_index;
					end
				end
			end
			S_A_MID: begin
				state_d = S_A_SUM;
			end
			S_A_SUM: begin
				state_d = S_RMW;
			end
			S_RMW: begin
				state_d    = S_IDLE;
				res_fire   = 1'b1;
				res_status = rmw_status;
				if (cmd_q == lfba_pkg::CMD_ALLOC) begin
					res_slot    = 16'(grant_slot);
					res_uniq    = uniq.next_value;
					res_persist = uniq.persist_next;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done      <= 1'b0;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			top_q     <= '1;
		end else begin
			state_q <= state_d;
			done    <= res_fire;
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + WB'(1);
				if (clr_idx_q == WB'(NUM_WORDS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if ((state_q == S_RMW) && do_write) begin
				top_q[t_q] <= (new_mid != '0);
			end
		end
	end

	// Command fields and level indices of the beat in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			idx_q <= block_index;
			t_q   <= (command == lfba_pkg::CMD_ALLOC) ? t_pick : MB'(named_slot >> 18);
			s_q   <= SB'(named_slot >> 12);
			w_q   <= WB'(named_slot >> 6);
		end else if (state_q == S_A_MID) begin
			s_q <= s_pick;
		end else if (state_q == S_A_SUM) begin
			w_q <= w_pick;
		end
		if (res_fire) begin
			status       <= res_status;
			slot_out     <= res_slot;
			uniq_value   <= res_uniq;
			persist_uniq <= res_persist;
		end
	end

`ifndef SYNTHESIS
	// The read-modify-write step always ends in exactly one result beat.
	a_rmw_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RMW) |=> done)
		else $error("read-modify-write step ended without a result beat");

	// No result while the clearing pass owns the memories.
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(clr_q) |-> !done)
		else $error("result beat during the clearing pass");

	// Only a successful allocate carries a counter value or a persist request.
	a_uniq_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != lfba_pkg::ST_OK)) |-> ((uniq_value == '0) && !persist_uniq))
		else $error("counter value on a failed command");
`endif

endmodule

>>> rtl/lfba_uniq_counter.sv
// Unique counter with a running residue modulo the persist interval.
module lfba_uniq_counter #(
	parameter int unsigned PERSIST_INTERVAL = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [lfba_pkg::UNIQ_W-1:0]  load_value,
	input  logic                         step,
	output lfba_pkg::uniq_status_t       status
);

	localparam int unsigned RB = $clog2(PERSIST_INTERVAL) + 1;
	localparam logic [RB-1:0] INTERVAL = RB'(PERSIST_INTERVAL);
	localparam int unsigned UW = lfba_pkg::UNIQ_W;
	// The reciprocal of the interval is rounded up and scaled by 2^QSH, so the quotient of
	// any counter value comes out exact. It is split in two halves for two narrow products.
	localparam int unsigned QSH = UW + RB - 1;
	localparam logic [63:0] RECIP =
		((64'd1 << QSH) + 64'(PERSIST_INTERVAL) - 64'd1) / 64'(PERSIST_INTERVAL);
	localparam logic [16:0] RECIP_LO = RECIP[16:0];
	localparam logic [15:0] RECIP_HI = RECIP[32:17];

	logic [UW-1:0]    count_q;
	logic [RB-1:0]    residue_q;
	logic [1:0]       phase_q;
	logic [UW+16:0]   prod_lo_q;
	logic [UW+15:0]   prod_hi_q;
	logic [UW-1:0]    quot_q;
	logic [UW+32:0]   prod_sum;
	logic [UW+RB-1:0] quot_scaled;
	logic [RB-1:0]    residue_inc;
	logic [RB-1:0]    residue_next;

	// The residue follows the counter; a wrap to zero is a multiple as well.
	assign residue_inc = residue_q + RB'(1);
	always_comb begin
		priority if (count_q == '1) begin
			residue_next = '0;
		end else if (residue_inc == INTERVAL) begin
			residue_next = '0;
		end else begin
			residue_next = residue_inc;
		end
	end

	// After a load the start value is reduced in three steps: the two partial products
	// with the reciprocal, the quotient, and the value less the quotient times the interval.
	assign prod_sum    = {prod_hi_q, 17'd0} + (UW+33)'(prod_lo_q);
	assign quot_scaled = (UW+RB)'(quot_q) * (UW+RB)'(INTERVAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			residue_q <= '0;
			phase_q   <= '0;
			prod_lo_q <= '0;
			prod_hi_q <= '0;
			quot_q    <= '0;
		end else if (load) begin
			count_q <= load_value;
			phase_q <= 2'd3;
		end else if (phase_q != 2'd0) begin
			prod_lo_q <= (UW+17)'(count_q) * (UW+17)'(RECIP_LO);
			prod_hi_q <= (UW+16)'(count_q) * (UW+16)'(RECIP_HI);
			quot_q    <= UW'(prod_sum >> QSH);
			residue_q <= RB'((UW+RB)'(count_q) - quot_scaled);
			phase_q   <= phase_q - 2'd1;
		end else if (step) begin
			count_q   <= count_q + UW'(1);
			residue_q <= residue_next;
		end
	end

	assign status.busy         = (phase_q != 2'd0);
	assign status.next_value   = count_q + UW'(1);
	assign status.persist_next = (residue_next == '0);

endmodule
